/* sv/vct_pkg.sv */
// ----------------------------------------------------------------------------
// vct_pkg: shared definitions for the viewport camera transform
// Fixed-point formats, field widths, action codes, the CORDIC arctangent
// table, saturation helper and the result groups of the shared units.
// ----------------------------------------------------------------------------
package vct_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int ZOOM_FRAC_BITS  = 22;
  localparam int CORDIC_STEPS    = 16;
  localparam int TRIG_FRAC       = 30;

  localparam int COORD_W  = 48;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int ZOOM_W   = 32;
  localparam int ANGLE_W  = 25;
  localparam int TURN_W   = 26;
  localparam int VIEW_W   = 15;
  localparam int HALF_W   = VIEW_W + COORD_FRAC_BITS - 1;
  localparam int TRIG_W   = 33;
  localparam int ZA_W     = 27;
  localparam int ATAN_W   = 22;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int LIMB_W   = 32;
  localparam int V_W      = 82;
  localparam int MAG_W    = 3 * LIMB_W;
  localparam int ACC_W    = 128;
  localparam int SUM_W    = 64;
  localparam int NUM_W    = V_W - (TRIG_FRAC - ZOOM_FRAC_BITS);
  localparam int ZP_W     = 2 * ZOOM_W - ZOOM_FRAC_BITS;
  localparam int WS_SHIFT = TRIG_FRAC + ZOOM_FRAC_BITS;
  localparam int WS_W     = ACC_W - WS_SHIFT;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((2 * COORD_W + ZOOM_W + TURN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_W + 1 + 7) / 8) * 8;

  localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int ANGLE_FULL    = 23592960;
  localparam int ANGLE_HALF    = 11796480;
  localparam int ANGLE_QUARTER = 5898240;
  localparam int CORDIC_GAIN   = 652032874;

  localparam logic [ZOOM_W-1:0] ZOOM_ONE = ZOOM_W'(64'd1 << ZOOM_FRAC_BITS);
  localparam logic [63:0] ZMIN_L   = ((64'd1 << ZOOM_FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [63:0] ZMAX_RAW = 64'd1000 << ZOOM_FRAC_BITS;
  localparam logic [63:0] ZMAX_L   = (ZMAX_RAW > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : ZMAX_RAW;
  localparam logic [63:0] Q_LIMIT  = 64'd1 << 60;

  localparam logic signed [SUM_W-1:0] COORD_MAX_S =
    (SUM_W'(1) <<< (COORD_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] COORD_MIN_S = ~COORD_MAX_S;

  localparam logic [2:0] ACT_HOME   = 3'd0;
  localparam logic [2:0] ACT_PAN    = 3'd1;
  localparam logic [2:0] ACT_ROTATE = 3'd2;
  localparam logic [2:0] ACT_ZOOM   = 3'd3;
  localparam logic [2:0] ACT_S2W    = 3'd4;
  localparam logic [2:0] ACT_W2S    = 3'd5;

  // Register indexes of the configuration port.
  localparam logic CFG_VIEW_WIDTH  = 1'b0;
  localparam logic CFG_VIEW_HEIGHT = 1'b1;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_res_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_res_t;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > COORD_MAX_S) r = COORD_MAX_S;
    else if (v < COORD_MIN_S) r = COORD_MIN_S;
    else r = v;
    return r[COORD_W-1:0];
  endfunction

endpackage

/* sv/vct_cordic.sv */
// ----------------------------------------------------------------------------
// vct_cordic: iterative CORDIC sine and cosine
// Folds the angle into [-90, 90] degrees, then runs one rotation step a cycle.
// ----------------------------------------------------------------------------
module vct_cordic import vct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ANGLE_W-1:0] angle,
  output trig_res_t          res
);

  localparam int IDX_W = $clog2(CORDIC_N);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic                     flip_r, flip_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic signed [TRIG_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZA_W-1:0]   z_r, z_nxt;

  always_comb begin
    logic signed [ZA_W-1:0]   za;
    logic signed [TRIG_W-1:0] xs, ys;
    logic [ZA_W-1:0]          at;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    za = $signed({{(ZA_W-ANGLE_W){1'b0}}, angle});
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = ZA_W'(atan_deg(5'(cnt_r)));
    if (start) begin
      if (za >= ANGLE_HALF) za = za - ZA_W'(ANGLE_FULL);
      flip_nxt = 1'b0;
      if (za > ANGLE_QUARTER) begin
        za = za - ZA_W'(ANGLE_HALF);
        flip_nxt = 1'b1;
      end else if (za < -ANGLE_QUARTER) begin
        za = za + ZA_W'(ANGLE_HALF);
        flip_nxt = 1'b1;
      end
      z_nxt    = za;
      x_nxt    = TRIG_W'(CORDIC_GAIN);
      y_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      if (cnt_r == IDX_W'(CORDIC_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign res.done  = done_r;
  assign res.cos_v = flip_r ? -x_r : x_r;
  assign res.sin_v = flip_r ? -y_r : y_r;

endmodule

/* sv/vct_div.sv */
// ----------------------------------------------------------------------------
// vct_div: restoring divider, one quotient bit per cycle
// Divides an unsigned numerator by the 32-bit zoom, quotient truncated.
// ----------------------------------------------------------------------------
module vct_div import vct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [ZOOM_W-1:0] den,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(NUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [ZOOM_W-1:0] rem_r, rem_nxt;
  logic [ZOOM_W-1:0] den_r, den_nxt;

  always_comb begin
    logic [ZOOM_W:0] rem_sh;
    logic            qb;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    qb       = (rem_sh >= {1'b0, den_r});
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qb ? ZOOM_W'(rem_sh - {1'b0, den_r}) : rem_sh[ZOOM_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], qb};
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;

endmodule

/* sv/viewport_camera_transform_core.sv */
// ----------------------------------------------------------------------------
// viewport_camera_transform_core: 2D viewport camera
// Keeps camera position, zoom and rotation; pans, rotates, zooms about a
// point and maps points between screen and world in fixed point.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  in_      slave      in_tvalid / in_tready    tuser action, tdata point/factor/turn
//  out_     master     out_tvalid / out_tready  tdata out_x, out_y, zoom_clamped
//  cfg_     write      cfg_we                   cfg_index, cfg_wdata
//
// One request is processed at a time. Home, rotate and the unused actions
// go straight from idle to the output state. Every other action first runs
// the CORDIC and a multiply-accumulate pass over 32-bit limbs. Pan and
// screen-to-world then run two serial divisions, zoom-at runs four of them
// plus the zoom product, and world-to-screen scales by the zoom instead.
// Reset is synchronous and restores the home camera; no clearing pass is
// needed. A request is accepted while a previous result still waits in the
// output register; a stalled output only holds the block at the point where
// the next result would be written.
//
module viewport_camera_transform_core import vct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [VIEW_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata fields, lowest bit up: pos_x, pos_y, zoom_factor, turn_degrees
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser fields: action
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata fields, lowest bit up: out_x, out_y, zoom_clamped
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TRIG    = 4'd1;
  localparam logic [3:0] S_MAC     = 4'd2;
  localparam logic [3:0] S_DIVGO   = 4'd3;
  localparam logic [3:0] S_DIVWAIT = 4'd4;
  localparam logic [3:0] S_ZMUL    = 4'd5;
  localparam logic [3:0] S_ZCLAMP  = 4'd6;
  localparam logic [3:0] S_MAG     = 4'd7;
  localparam logic [3:0] S_MAGFIN  = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic signed [COORD_W-1:0] cam_x_r, cam_x_nxt, cam_y_r, cam_y_nxt;
  logic [ZOOM_W-1:0]         zoom_r, zoom_nxt;
  logic [ANGLE_W-1:0]        angle_r, angle_nxt;
  logic [VIEW_W-1:0]         view_w_r, view_w_nxt, view_h_r, view_h_nxt;
  logic [2:0]                act_r, act_nxt;
  logic [ZOOM_W-1:0]         fac_r, fac_nxt;
  logic signed [DIFF_W-1:0]  opa_r, opa_nxt, opb_r, opb_nxt;
  logic signed [TRIG_W-1:0]  cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [V_W-1:0]     vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [SUM_W-1:0]   wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                      clamped_r, clamped_nxt;
  logic                      comp_r, comp_nxt;
  logic                      pass_r, pass_nxt;
  logic [1:0]                step_r, step_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                      out_clamp_r, out_clamp_nxt;

  logic                      trig_start, div_start;
  trig_res_t                 trig_res;
  div_res_t                  div_res;
  logic [NUM_W-1:0]          div_num;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      acc_shift;

  logic signed [V_W-1:0]     vsel;
  logic [V_W-1:0]            vabs;
  logic [MAG_W-1:0]          magw;
  logic signed [DIFF_W-1:0]  halfw_s, halfh_s;

  vct_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (angle_r),
    .res   (trig_res)
  );

  vct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (zoom_r),
    .res   (div_res)
  );

  assign halfw_s = DIFF_W'({view_w_r, {(COORD_FRAC_BITS-1){1'b0}}});
  assign halfh_s = DIFF_W'({view_h_r, {(COORD_FRAC_BITS-1){1'b0}}});

  // Component under work and its magnitude; feeds both divider and scaler.
  assign vsel    = comp_r ? vy_r : vx_r;
  assign vabs    = vsel[V_W-1] ? V_W'(-vsel) : V_W'(vsel);
  assign magw    = {{(MAG_W-V_W){1'b0}}, vabs};
  assign div_num = vabs[V_W-1:TRIG_FRAC-ZOOM_FRAC_BITS];

  // Shared multiplier operand selection. The rotation terms are built from
  // a signed high limb and an unsigned low limb of each 49-bit operand.
  always_comb begin
    logic signed [DIFF_W-1:0] ma, mb;
    logic signed [TRIG_W-1:0] k1, k2, nsin;
    logic                     w2s;
    nsin = -sin_r;
    w2s  = (act_r == ACT_W2S);
    if (!comp_r) begin
      ma = opa_r;
      mb = opb_r;
      k1 = cos_r;
      k2 = w2s ? nsin : sin_r;
    end else if (w2s) begin
      ma = opa_r;
      mb = opb_r;
      k1 = sin_r;
      k2 = cos_r;
    end else begin
      ma = opb_r;
      mb = opa_r;
      k1 = cos_r;
      k2 = nsin;
    end
    mul_a     = '0;
    mul_b     = '0;
    acc_shift = 1'b0;
    case (state_r)
      S_MAC: begin
        case (step_r)
          2'd0: begin
            mul_a = MUL_W'($signed(ma[DIFF_W-1:LIMB_W]));
            mul_b = k1;
          end
          2'd1: begin
            mul_a = MUL_W'($signed(mb[DIFF_W-1:LIMB_W]));
            mul_b = k2;
          end
          2'd2: begin
            mul_a = {1'b0, ma[LIMB_W-1:0]};
            mul_b = k1;
            acc_shift = 1'b1;
          end
          default: begin
            mul_a = {1'b0, mb[LIMB_W-1:0]};
            mul_b = k2;
          end
        endcase
      end
      S_ZMUL: begin
        mul_a = {1'b0, zoom_r};
        mul_b = {1'b0, fac_r};
      end
      S_MAG: begin
        case (step_r)
          2'd0: mul_a = {1'b0, magw[3*LIMB_W-1:2*LIMB_W]};
          2'd1: mul_a = {1'b0, magw[2*LIMB_W-1:LIMB_W]};
          default: mul_a = {1'b0, magw[LIMB_W-1:0]};
        endcase
        mul_b     = {1'b0, zoom_r};
        acc_shift = (step_r != 2'd0);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_clamp_r, out_y_r, out_x_r});

  always_comb begin
    logic signed [COORD_W-1:0] px, py;
    logic signed [DIFF_W-1:0]  px_e, py_e;
    logic signed [TURN_W-1:0]  td;
    logic signed [ANGLE_W+1:0] asum;
    logic signed [ACC_W-1:0]   prod_e;
    logic [SUM_W-1:0]          qmag;
    logic signed [SUM_W-1:0]   q, cam_c, w_c;
    logic [ZP_W-1:0]           zfull;
    logic [WS_W-1:0]           ws;

    state_nxt     = state_r;
    cam_x_nxt     = cam_x_r;
    cam_y_nxt     = cam_y_r;
    zoom_nxt      = zoom_r;
    angle_nxt     = angle_r;
    view_w_nxt    = view_w_r;
    view_h_nxt    = view_h_r;
    act_nxt       = act_r;
    fac_nxt       = fac_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    clamped_nxt   = clamped_r;
    comp_nxt      = comp_r;
    pass_nxt      = pass_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_clamp_nxt = out_clamp_r;
    trig_start    = 1'b0;
    div_start     = 1'b0;

    px   = $signed(in_tdata[COORD_W-1:0]);
    py   = $signed(in_tdata[2*COORD_W-1:COORD_W]);
    td   = $signed(in_tdata[2*COORD_W+ZOOM_W +: TURN_W]);
    px_e = DIFF_W'(px);
    py_e = DIFF_W'(py);

    prod_e = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    cam_c  = comp_r ? SUM_W'(cam_y_r) : SUM_W'(cam_x_r);
    w_c    = comp_r ? wy_r : wx_r;
    qmag   = (div_res.quot > NUM_W'(Q_LIMIT)) ? Q_LIMIT : SUM_W'(div_res.quot);
    q      = vsel[V_W-1] ? -$signed(qmag) : $signed(qmag);
    zfull  = acc_r[2*ZOOM_W-1:ZOOM_FRAC_BITS];
    ws     = acc_r[ACC_W-1:WS_SHIFT];
    asum   = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      if (cfg_index == CFG_VIEW_WIDTH) view_w_nxt = cfg_wdata;
      if (cfg_index == CFG_VIEW_HEIGHT) view_h_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt     = in_tuser;
          fac_nxt     = in_tdata[2*COORD_W +: ZOOM_W];
          clamped_nxt = 1'b0;
          pass_nxt    = 1'b0;
          comp_nxt    = 1'b0;
          step_nxt    = '0;
          acc_nxt     = '0;
          state_nxt   = S_OUT;
          case (in_tuser)
            ACT_HOME: begin
              cam_x_nxt = '0;
              cam_y_nxt = '0;
              zoom_nxt  = ZOOM_ONE;
              angle_nxt = '0;
            end
            ACT_ROTATE: begin
              // Delta limited to a full turn, then one wrap into [0, 360).
              if (td > ANGLE_FULL) td = TURN_W'(ANGLE_FULL);
              if (td < -ANGLE_FULL) td = -TURN_W'(ANGLE_FULL);
              asum = $signed({2'b00, angle_r}) + (ANGLE_W+2)'(td);
              if (asum >= ANGLE_FULL) asum = asum - (ANGLE_W+2)'(ANGLE_FULL);
              else if (asum < 0) asum = asum + (ANGLE_W+2)'(ANGLE_FULL);
              angle_nxt = asum[ANGLE_W-1:0];
            end
            ACT_PAN: begin
              opa_nxt    = px_e;
              opb_nxt    = -py_e;
              trig_start = 1'b1;
              state_nxt  = S_TRIG;
            end
            ACT_ZOOM, ACT_S2W: begin
              opa_nxt    = px_e - halfw_s;
              opb_nxt    = halfh_s - py_e;
              trig_start = 1'b1;
              state_nxt  = S_TRIG;
            end
            ACT_W2S: begin
              opa_nxt    = px_e - DIFF_W'(cam_x_r);
              opb_nxt    = py_e - DIFF_W'(cam_y_r);
              trig_start = 1'b1;
              state_nxt  = S_TRIG;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      S_TRIG: begin
        if (trig_res.done) begin
          cos_nxt   = trig_res.cos_v;
          sin_nxt   = trig_res.sin_v;
          state_nxt = S_MAC;
        end
      end

      S_MAC: begin
        acc_nxt = (acc_shift ? (acc_r <<< LIMB_W) : acc_r) + prod_e;
        if (step_r == 2'd3) begin
          step_nxt = '0;
          if (!comp_r) begin
            vx_nxt   = acc_nxt[V_W-1:0];
            comp_nxt = 1'b1;
            acc_nxt  = '0;
          end else begin
            vy_nxt    = acc_nxt[V_W-1:0];
            comp_nxt  = 1'b0;
            acc_nxt   = '0;
            state_nxt = (act_r == ACT_W2S) ? S_MAG : S_DIVGO;
          end
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end

      S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = S_DIVWAIT;
      end

      S_DIVWAIT: begin
        if (div_res.done) begin
          case (act_r)
            ACT_PAN: begin
              if (comp_r) cam_y_nxt = sat48(cam_c - q);
              else cam_x_nxt = sat48(cam_c - q);
            end
            ACT_S2W: begin
              if (comp_r) res_y_nxt = sat48(cam_c + q);
              else res_x_nxt = sat48(cam_c + q);
            end
            default: begin
              // Zoom-at: first pass finds the world point under the cursor,
              // second pass places the camera so that point stays put.
              if (!pass_r) begin
                if (comp_r) wy_nxt = cam_c + q;
                else wx_nxt = cam_c + q;
              end else begin
                if (comp_r) cam_y_nxt = sat48(w_c - q);
                else cam_x_nxt = sat48(w_c - q);
              end
            end
          endcase
          if (!comp_r) begin
            comp_nxt  = 1'b1;
            state_nxt = S_DIVGO;
          end else begin
            comp_nxt  = 1'b0;
            state_nxt = (act_r == ACT_ZOOM && !pass_r) ? S_ZMUL : S_OUT;
          end
        end
      end

      S_ZMUL: begin
        acc_nxt   = prod_e;
        state_nxt = S_ZCLAMP;
      end

      S_ZCLAMP: begin
        if (zfull < ZP_W'(ZMIN_L)) begin
          zoom_nxt    = ZOOM_W'(ZMIN_L);
          clamped_nxt = 1'b1;
        end else if (zfull > ZP_W'(ZMAX_L)) begin
          zoom_nxt    = ZOOM_W'(ZMAX_L);
          clamped_nxt = 1'b1;
        end else begin
          zoom_nxt = zfull[ZOOM_W-1:0];
        end
        pass_nxt  = 1'b1;
        comp_nxt  = 1'b0;
        state_nxt = S_DIVGO;
      end

      S_MAG: begin
        acc_nxt = (acc_shift ? (acc_r <<< LIMB_W) : acc_r) + prod_e;
        if (step_r == 2'd2) begin
          step_nxt  = '0;
          state_nxt = S_MAGFIN;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end

      S_MAGFIN: begin
        qmag = (ws > WS_W'(Q_LIMIT)) ? Q_LIMIT : SUM_W'(ws);
        q    = vsel[V_W-1] ? -$signed(qmag) : $signed(qmag);
        if (comp_r) res_y_nxt = sat48(SUM_W'(halfh_s) - q);
        else res_x_nxt = sat48(SUM_W'(halfw_s) + q);
        acc_nxt = '0;
        if (!comp_r) begin
          comp_nxt  = 1'b1;
          state_nxt = S_MAG;
        end else begin
          comp_nxt  = 1'b0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (act_r == ACT_S2W || act_r == ACT_W2S) begin
            out_x_nxt = res_x_r;
            out_y_nxt = res_y_r;
          end else begin
            out_x_nxt = cam_x_r;
            out_y_nxt = cam_y_r;
          end
          out_clamp_nxt = clamped_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      zoom_r      <= ZOOM_ONE;
      angle_r     <= '0;
      view_w_r    <= '0;
      view_h_r    <= '0;
      out_valid_r <= 1'b0;
      comp_r      <= 1'b0;
      pass_r      <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cam_x_r     <= cam_x_nxt;
      cam_y_r     <= cam_y_nxt;
      zoom_r      <= zoom_nxt;
      angle_r     <= angle_nxt;
      view_w_r    <= view_w_nxt;
      view_h_r    <= view_h_nxt;
      out_valid_r <= out_valid_nxt;
      comp_r      <= comp_nxt;
      pass_r      <= pass_nxt;
      step_r      <= step_nxt;
    end
    act_r       <= act_nxt;
    fac_r       <= fac_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    cos_r       <= cos_nxt;
    sin_r       <= sin_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    clamped_r   <= clamped_nxt;
    acc_r       <= acc_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

endmodule
